// ===== hdl/srs_pkg.sv =====
`timescale 1ns / 1ps
package srs_pkg;

    localparam int unsigned MAX_DEPTH       = 63;
    localparam int unsigned MAX_INDENT_COLS = 63;

    localparam int unsigned LEVEL_W  = 6;
    localparam int unsigned WIDTH_W  = 4;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned PROD_W   = LEVEL_W + WIDTH_W;

    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam logic [0:0] REG_INDENT_WIDTH = 1'b0;
    localparam logic [0:0] REG_TAB_MODE     = 1'b1;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef enum logic [1:0] {
        LEX_NORMAL   = 2'd0,
        LEX_STRING   = 2'd1,
        LEX_TEMPLATE = 2'd2,
        LEX_COMMENT  = 2'd3
    } lex_mode_t;

    // One emission job: count fill bytes, then the source byte itself.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               tab;
        logic [7:0]         data;
    } srs_cmd_t;

endpackage

// ===== hdl/srs_front.sv =====
`timescale 1ns / 1ps
module srs_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [3:0]            cfg_data,
    input  logic                  accept,
    input  logic [7:0]            in_byte,
    input  logic                  doc_end,
    output logic                  cmd_push,
    output srs_pkg::srs_cmd_t     cmd
);
    import srs_pkg::*;

    logic [WIDTH_W-1:0] indent_width_reg;
    logic               tab_mode_reg;

    lex_mode_t          lex_mode_reg, lex_mode_next;
    logic               quote_kind_reg, quote_kind_next;
    logic               escape_reg, escape_next;
    logic               slash_reg, slash_next;
    logic               line_start_reg, line_start_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic [LEVEL_W-1:0] level_adj;
    logic               do_indent;
    logic               drop;
    logic               done;
    logic [PROD_W-1:0]  space_cols;
    logic [COUNT_W-1:0] indent_count;
    logic [7:0]         close_quote;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            indent_width_reg <= WIDTH_W'(4);
            tab_mode_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INDENT_WIDTH: indent_width_reg <= cfg_data[WIDTH_W-1:0];
                REG_TAB_MODE:     tab_mode_reg     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode_reg   <= LEX_NORMAL;
            quote_kind_reg <= 1'b0;
            escape_reg     <= 1'b0;
            slash_reg      <= 1'b0;
            line_start_reg <= 1'b1;
            level_reg      <= '0;
        end
        else if (accept)
        begin
            lex_mode_reg   <= lex_mode_next;
            quote_kind_reg <= quote_kind_next;
            escape_reg     <= escape_next;
            slash_reg      <= slash_next;
            line_start_reg <= line_start_next;
            level_reg      <= level_next;
        end
    end

    assign close_quote = quote_kind_reg ? CH_SQUOTE : CH_DQUOTE;

    always_comb
    begin
        lex_mode_next   = lex_mode_reg;
        quote_kind_next = quote_kind_reg;
        escape_next     = escape_reg;
        slash_next      = slash_reg;
        line_start_next = line_start_reg;
        level_next      = level_reg;
        level_adj       = level_reg;
        do_indent       = 1'b0;
        drop            = 1'b0;
        done            = 1'b0;

        case (lex_mode_reg)
            LEX_STRING, LEX_TEMPLATE:
            begin
                line_start_next = 1'b0;
                if (escape_reg)
                begin
                    escape_next = 1'b0;
                end
                else if (in_byte == CH_BACKSLASH)
                begin
                    escape_next = 1'b1;
                end
                else if (lex_mode_reg == LEX_TEMPLATE)
                begin
                    if (in_byte == CH_BACKTICK)
                    begin
                        lex_mode_next = LEX_NORMAL;
                    end
                end
                else if (in_byte == close_quote)
                begin
                    lex_mode_next = LEX_NORMAL;
                end
            end
            LEX_COMMENT:
            begin
                if (in_byte == CH_NEWLINE)
                begin
                    lex_mode_next   = LEX_NORMAL;
                    line_start_next = 1'b1;
                end
            end
            default:
            begin
                // A slash after a slash opens a line comment and is passed as is.
                if (slash_reg)
                begin
                    slash_next = 1'b0;
                    if (in_byte == CH_SLASH)
                    begin
                        lex_mode_next = LEX_COMMENT;
                        done          = 1'b1;
                    end
                end
                if (!done && line_start_reg)
                begin
                    if (in_byte == CH_SPACE || in_byte == CH_TAB)
                    begin
                        drop = 1'b1;
                        done = 1'b1;
                    end
                    else if (in_byte == CH_NEWLINE)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        if (in_byte == CH_RBRACE && level_reg != '0)
                        begin
                            level_adj = level_reg - LEVEL_W'(1);
                        end
                        level_next      = level_adj;
                        do_indent       = 1'b1;
                        line_start_next = 1'b0;
                    end
                end
                if (!done)
                begin
                    if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE)
                    begin
                        lex_mode_next   = LEX_STRING;
                        quote_kind_next = (in_byte == CH_SQUOTE);
                        escape_next     = 1'b0;
                    end
                    else if (in_byte == CH_BACKTICK)
                    begin
                        lex_mode_next = LEX_TEMPLATE;
                        escape_next   = 1'b0;
                    end
                    else if (in_byte == CH_SLASH)
                    begin
                        slash_next = 1'b1;
                    end
                    else if (in_byte == CH_LBRACE)
                    begin
                        if (level_adj < LEVEL_W'(MAX_DEPTH))
                        begin
                            level_next = level_adj + LEVEL_W'(1);
                        end
                    end
                    else if (in_byte == CH_NEWLINE)
                    begin
                        line_start_next = 1'b1;
                    end
                end
            end
        endcase

        // The end of a document returns the scanner to its reset state.
        if (doc_end)
        begin
            lex_mode_next   = LEX_NORMAL;
            quote_kind_next = 1'b0;
            escape_next     = 1'b0;
            slash_next      = 1'b0;
            line_start_next = 1'b1;
            level_next      = '0;
        end
    end

    assign space_cols = PROD_W'(level_adj) * PROD_W'(indent_width_reg);

    always_comb
    begin
        if (!do_indent)
        begin
            indent_count = '0;
        end
        else if (tab_mode_reg)
        begin
            indent_count = (PROD_W'(level_adj) > PROD_W'(MAX_INDENT_COLS)) ?
                           COUNT_W'(MAX_INDENT_COLS) : COUNT_W'(level_adj);
        end
        else
        begin
            indent_count = (space_cols > PROD_W'(MAX_INDENT_COLS)) ?
                           COUNT_W'(MAX_INDENT_COLS) : space_cols[COUNT_W-1:0];
        end
    end

    assign cmd_push  = accept && !drop;
    assign cmd.count = indent_count;
    assign cmd.tab   = tab_mode_reg;
    assign cmd.data  = in_byte;

endmodule

// ===== hdl/srs_cmdq.sv =====
`timescale 1ns / 1ps
module srs_cmdq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  srs_pkg::srs_cmd_t     wr_cmd,
    input  logic                  rd_en,
    output srs_pkg::srs_cmd_t     rd_cmd,
    output logic                  q_empty,
    output logic                  q_full
);
    import srs_pkg::*;

    srs_cmd_t             entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0]   count_reg, count_next;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + CMDQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + CMDQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + CMDQ_CW'(wr_en) - CMDQ_CW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== hdl/srs_back.sv =====
`timescale 1ns / 1ps
module srs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  srs_pkg::srs_cmd_t     head,
    input  logic                  head_empty,
    output logic                  head_take,
    input  logic                  pop,
    output logic                  empty,
    output logic [7:0]            out_byte,
    output logic                  run_last
);
    import srs_pkg::*;

    logic               cur_valid_reg, cur_valid_next;
    logic [COUNT_W-1:0] cur_count_reg, cur_count_next;
    logic               cur_tab_reg, cur_tab_next;
    logic [7:0]         cur_data_reg, cur_data_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               run_last_reg, run_last_next;

    logic               advance;

    // The output register is refilled whenever it is free or being taken.
    assign advance   = !out_valid_reg || pop;
    assign head_take = advance && !cur_valid_reg && !head_empty;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_count_next = cur_count_reg;
        cur_tab_next   = cur_tab_reg;
        cur_data_next  = cur_data_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;

        if (advance)
        begin
            if (cur_valid_reg)
            begin
                out_valid_next = 1'b1;
                if (cur_count_reg != '0)
                begin
                    out_byte_next  = cur_tab_reg ? CH_TAB : CH_SPACE;
                    run_last_next  = 1'b0;
                    cur_count_next = cur_count_reg - COUNT_W'(1);
                end
                else
                begin
                    out_byte_next  = cur_data_reg;
                    run_last_next  = 1'b1;
                    cur_valid_next = 1'b0;
                end
            end
            else if (!head_empty)
            begin
                out_valid_next = 1'b1;
                if (head.count != '0)
                begin
                    out_byte_next  = head.tab ? CH_TAB : CH_SPACE;
                    run_last_next  = 1'b0;
                    cur_valid_next = 1'b1;
                    cur_count_next = head.count - COUNT_W'(1);
                    cur_tab_next   = head.tab;
                    cur_data_next  = head.data;
                end
                else
                begin
                    out_byte_next = head.data;
                    run_last_next = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_count_reg <= cur_count_next;
        cur_tab_reg   <= cur_tab_next;
        cur_data_reg  <= cur_data_next;
        out_byte_reg  <= out_byte_next;
        run_last_reg  <= run_last_next;
    end

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign run_last = run_last_reg;

endmodule

// ===== hdl/source_reindent_stream.sv =====
`timescale 1ns / 1ps
// Source re-indenter: takes text one byte per item and emits it re-indented.
// Input side is a queue write port: an item (in_byte, doc_end) is taken at a
// clock edge with push high and full low. Result side is a queue read port:
// while empty is low, out_byte/run_last show the oldest result, taken at an
// edge with pop high. run_last marks the last result of one input byte.
// Leading blanks of a line produce no result at all.
// Configuration: cfg_we with cfg_index 0 (indent_width) or 1 (tab_mode);
// the user writes it only while the block is idle; the block does not enforce this.
// The first result of an item passes the job queue and then the output
// register before it is on the ports. The front scanner takes one item per
// cycle while its four-entry job queue has room; the back end emits one byte
// per cycle while results are popped, so an item yields its indentation
// bytes (0..63) and then its own byte.
// When pop is held low the output register holds, the job queue fills and
// full rises; nothing is lost. Reset clears all queues, returns the
// scanner to normal code at line start with level zero, and sets
// indent_width to 4 and tab_mode to 0.
module source_reindent_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        doc_end,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        run_last
);
    import srs_pkg::*;

    logic     accept;
    logic     cmd_push;
    srs_cmd_t cmd;
    srs_cmd_t head;
    logic     head_empty;
    logic     head_take;

    assign accept = push && !full;

    srs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_byte   (in_byte),
        .doc_end   (doc_end),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    srs_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_cmd  (cmd),
        .rd_en   (head_take),
        .rd_cmd  (head),
        .q_empty (head_empty),
        .q_full  (full)
    );

    srs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_take  (head_take),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .run_last   (run_last)
    );

endmodule
